@@ rtl/drolm_pkg.sv @@
package drolm_pkg;

    localparam int ADDR_W      = 32;
    localparam int LATENCY_W   = 12;
    localparam int BANK_OUT_W  = 2;
    localparam int ROW_W       = 24;
    localparam int COL_W       = 16;
    localparam int TIME_W      = 32;
    localparam int TIMING_W    = 10;
    localparam int CFG_INDEX_W = 4;

    localparam logic                MAPPING_MODE_RESET     = 1'b1;
    localparam logic [TIMING_W-1:0] ACTIVATE_TIME_RESET    = 10'd100;
    localparam logic [TIMING_W-1:0] COLUMN_TIME_RESET      = 10'd50;
    localparam logic [TIMING_W-1:0] PRECHARGE_CYCLES_RESET = 10'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAPPING_MODE     = 4'd0,
        REG_ACTIVATE_TIME    = 4'd1,
        REG_COLUMN_TIME      = 4'd2,
        REG_PRECHARGE_CYCLES = 4'd3
    } reg_index_t;

    typedef enum logic {
        MAP_ROW_INTERLEAVE   = 1'b0,
        MAP_BLOCK_INTERLEAVE = 1'b1
    } map_mode_t;

    typedef struct packed {
        map_mode_t           mapping_mode;
        logic [TIMING_W-1:0] activate_time;
        logic [TIMING_W-1:0] column_time;
        logic [TIMING_W-1:0] precharge_cycles;
    } cfg_t;

    typedef struct packed {
        logic was_open;
        logic hit;
    } lookup_t;

endpackage

@@ rtl/drolm_addr_map.sv @@
module drolm_addr_map
    import drolm_pkg::*;
#(
    parameter int BANK_COUNT   = 4,
    parameter int COLUMN_COUNT = 1024,
    parameter int BLOCK_BYTES  = 64,
    localparam int BW = $clog2(BANK_COUNT)
) (
    input  logic [ADDR_W-1:0] address,
    input  map_mode_t         mapping_mode,
    output logic [BW-1:0]     bank,
    output logic [ROW_W-1:0]  row,
    output logic [COL_W-1:0]  column
);

    localparam int CW = $clog2(COLUMN_COUNT);
    localparam int OW = $clog2(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] OFFSET_MASK = (ADDR_W'(1) << OW) - ADDR_W'(1);
    localparam logic [ADDR_W-1:0] UPPER_MASK  = ((ADDR_W'(1) << CW) - ADDR_W'(1)) << OW;
    localparam logic [BW:0]       BANK_LIMIT  = (BW + 1)'(BANK_COUNT);

    logic [ADDR_W-1:0] upper;
    logic [ADDR_W-1:0] row_full;
    logic [ADDR_W-1:0] col_full;
    logic [BW-1:0]     bank_raw;
    logic [BW:0]       bank_wrap;

    always_comb begin
        upper = address >> (OW + BW);
        if (mapping_mode == MAP_ROW_INTERLEAVE) begin
            col_full = (address >> 2) & ((ADDR_W'(1) << CW) - ADDR_W'(1));
            bank_raw = address[2 + CW +: BW];
            row_full = address >> (2 + CW + BW);
        end else begin
            col_full = (address & OFFSET_MASK) | (upper & UPPER_MASK);
            bank_raw = address[OW +: BW];
            row_full = upper;
        end
        bank_wrap = {1'b0, bank_raw} - BANK_LIMIT;
        bank      = ({1'b0, bank_raw} >= BANK_LIMIT) ? bank_wrap[BW-1:0] : bank_raw;
        row       = row_full[ROW_W-1:0];
        column    = col_full[COL_W-1:0];
    end

endmodule

@@ rtl/drolm_bank_state.sv @@
module drolm_bank_state
    import drolm_pkg::*;
#(
    parameter int BANK_COUNT = 4,
    localparam int BW = $clog2(BANK_COUNT)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [BW-1:0]    lookup_bank,
    input  logic [ROW_W-1:0] lookup_row,
    input  logic             update,
    output lookup_t          lookup
);

    logic [BANK_COUNT-1:0] open_valid_reg;
    logic [ROW_W-1:0]      open_row_reg [BANK_COUNT];

    always_comb begin
        lookup.was_open = open_valid_reg[lookup_bank];
        lookup.hit      = open_valid_reg[lookup_bank]
                          && (open_row_reg[lookup_bank] == lookup_row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_valid_reg <= '0;
        end else if (update) begin
            open_valid_reg[lookup_bank] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (update && !lookup.hit) begin
            open_row_reg[lookup_bank] <= lookup_row;
        end
    end

endmodule

@@ rtl/dram_open_row_latency_model_core.sv @@
// Each accepted address beat is held in the stage register and moves into the result
// register when that register is empty or its beat is taken (m_ready).
// Throughput: one address per cycle while the result is not stalled; the bank
// table and the running time are updated as each beat moves into the result
// register, so accesses to the same bank may follow each other in consecutive cycles.
// Reset (aresetn low at a clock edge) closes every row, clears the running
// time, restores the default timing registers and empties both stages.
module dram_open_row_latency_model_core
    import drolm_pkg::*;
#(
    parameter int BANK_COUNT   = 4,
    parameter int COLUMN_COUNT = 1024,
    parameter int BLOCK_BYTES  = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ADDR_W-1:0]      s_address,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LATENCY_W-1:0]   m_latency,
    output logic [BANK_OUT_W-1:0]  m_bank,
    output logic [ROW_W-1:0]       m_row,
    output logic [COL_W-1:0]       m_column,
    output logic                   m_row_hit,
    output logic [TIME_W-1:0]      m_elapsed_time,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TIMING_W-1:0]    cfg_data
);

    localparam int BW = $clog2(BANK_COUNT);

    cfg_t                  cfg_reg;
    logic                  stage_valid_reg;
    logic [ADDR_W-1:0]     stage_addr_reg;
    logic                  out_valid_reg;
    logic [LATENCY_W-1:0]  out_latency_reg;
    logic [BANK_OUT_W-1:0] out_bank_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_column_reg;
    logic                  out_hit_reg;
    logic [TIME_W-1:0]     running_time_reg;
    logic [TIME_W-1:0]     running_time_next;

    logic                  out_load;
    logic                  advance;
    logic [BW-1:0]         dec_bank;
    logic [ROW_W-1:0]      dec_row;
    logic [COL_W-1:0]      dec_column;
    logic [BW+1:0]         dec_bank_ext;
    lookup_t               lookup;
    logic [LATENCY_W-1:0]  latency;
    logic [TIME_W:0]       time_sum;

    assign out_load  = !out_valid_reg || m_ready;
    assign advance   = stage_valid_reg && out_load;
    assign s_ready   = !stage_valid_reg || out_load;
    assign cfg_ready = 1'b1;

    drolm_addr_map #(
        .BANK_COUNT   (BANK_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .BLOCK_BYTES  (BLOCK_BYTES)
    ) u_addr_map (
        .address      (stage_addr_reg),
        .mapping_mode (cfg_reg.mapping_mode),
        .bank         (dec_bank),
        .row          (dec_row),
        .column       (dec_column)
    );

    drolm_bank_state #(
        .BANK_COUNT (BANK_COUNT)
    ) u_bank_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lookup_bank (dec_bank),
        .lookup_row  (dec_row),
        .update      (advance),
        .lookup      (lookup)
    );

    always_comb begin
        latency = LATENCY_W'(cfg_reg.column_time);
        if (!lookup.hit) begin
            latency = latency + LATENCY_W'(cfg_reg.activate_time);
            if (lookup.was_open) begin
                latency = latency + LATENCY_W'(cfg_reg.precharge_cycles);
            end
        end
        time_sum          = {1'b0, running_time_reg} + (TIME_W + 1)'(latency);
        running_time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
        dec_bank_ext      = (BW + 2)'(dec_bank);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mapping_mode     <= map_mode_t'(MAPPING_MODE_RESET);
            cfg_reg.activate_time    <= ACTIVATE_TIME_RESET;
            cfg_reg.column_time      <= COLUMN_TIME_RESET;
            cfg_reg.precharge_cycles <= PRECHARGE_CYCLES_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAPPING_MODE:     cfg_reg.mapping_mode     <= map_mode_t'(cfg_data[0]);
                REG_ACTIVATE_TIME:    cfg_reg.activate_time    <= cfg_data;
                REG_COLUMN_TIME:      cfg_reg.column_time      <= cfg_data;
                REG_PRECHARGE_CYCLES: cfg_reg.precharge_cycles <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            running_time_reg <= '0;
        end else begin
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= stage_valid_reg;
            end
            if (advance) begin
                running_time_reg <= running_time_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_addr_reg <= s_address;
        end
        if (advance) begin
            out_latency_reg <= latency;
            out_bank_reg    <= dec_bank_ext[BANK_OUT_W-1:0];
            out_row_reg     <= dec_row;
            out_column_reg  <= dec_column;
            out_hit_reg     <= lookup.hit;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_latency      = out_latency_reg;
    assign m_bank         = out_bank_reg;
    assign m_row          = out_row_reg;
    assign m_column       = out_column_reg;
    assign m_row_hit      = out_hit_reg;
    assign m_elapsed_time = running_time_reg;

`ifndef ASSERT_OFF
    a_time_monotonic : assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> running_time_reg >= $past(running_time_reg))
        else $error("Running time decreased.");

    a_hit_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_hit |-> m_latency == LATENCY_W'(cfg_reg.column_time))
        else $error("Row hit carries more than the column time.");

    a_miss_latency : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_row_hit |->
            m_latency >= LATENCY_W'(cfg_reg.column_time) + LATENCY_W'(cfg_reg.activate_time))
        else $error("Row miss latency is below activate plus column time.");

    a_stall_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("Input beat refused while the result side is free.");
`endif

endmodule
